// File: hw/rtl/tccw_pkg.sv
// ============================================================================
// Text console character writer: shared package
// Geometry constants, payload and control structs, command and state codes.
// ============================================================================
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int RIGHT_PAD = 2;
    localparam int TAB_STEP  = 4;
    localparam int CELLS     = ROWS * COLUMNS;

    // Internal widths
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int CELL_W = $clog2(CELLS);
    localparam int SW_W   = $clog2(CELLS + 1);
    localparam int CALC_W = $clog2(CELLS + 2);

    // Field widths
    localparam int CUR_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int WORD_W = ATTR_W + CHAR_W;

    // Character codes and reset attribute
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    // Register map (word index taken from paddr[2])
    localparam int  PADDR_W        = 3;
    localparam int  PDATA_W        = 32;
    localparam logic REG_COLOR_ATTR = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_addr;
    } t_in;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [4:0]  cur_row;
        logic [6:0]  cur_column;
        logic [15:0] cell_data;
    } t_out;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_COPY,
        S_FILL,
        S_WRITE,
        S_READ,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        SWEEP_NONE,
        SWEEP_COPY,
        SWEEP_FILL
    } t_sweep;

    typedef struct packed {
        logic   accept;
        logic   decode;
        logic   sweep_load;
        logic   sweep_from_row;
        t_sweep sweep_op;
        logic   reset_attr;
        logic   do_write;
        logic   do_read;
        logic   load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_scroll;
        logic pend_clear;
        logic pend_wr;
        logic pend_rd;
        logic copy_last;
        logic fill_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/text_console_char_writer.sv
// ============================================================================
// Text console character writer
// Cursor-driven console over a cell store: put char, clear, delete, read.
// ============================================================================
// Each command is accepted, decoded and dispatched; newline, tab and an
// out-of-range read then go to the result, while put char, delete and an in-range
// read first make one cell access. A scroll first copies the rows up and blanks the
// bottom row through the single store write port, and a clear blanks every cell.
// Throughput: one command at a time, the next accepted once the result is in the
// output register. After reset a clearing pass blanks the store while input stall
// stays high; color_attr resets to 7.
module text_console_char_writer
    import tccw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;
    logic [ATTR_W-1:0] r_color_attr;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_COLOR_ATTR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_color_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(r_color_attr) : '0;

    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tccw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_in_data    (i_in_data),
        .i_color_attr (r_color_attr),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// File: hw/rtl/tccw_ctrl.sv
// ============================================================================
// Text console character writer: controller
// Sequences accept, decode, scroll copy, blank fill, cell access and result.
// ============================================================================
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_status.pend_scroll) n_state = S_COPY;
                else if (i_status.pend_clear) n_state = S_FILL;
                else if (i_status.pend_wr) n_state = S_WRITE;
                else if (i_status.pend_rd) n_state = S_READ;
                else n_state = S_RESP;
            end
            S_COPY: begin
                if (i_status.copy_last) n_state = S_FILL;
            end
            S_FILL: begin
                if (i_status.fill_last) n_state = i_status.pend_wr ? S_WRITE : S_RESP;
            end
            S_WRITE: begin
                n_state = S_RESP;
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_op   = SWEEP_FILL;
                o_cmd.reset_attr = 1'b1;
            end
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            S_DISPATCH: begin
                o_cmd.sweep_load = 1'b1;
            end
            S_COPY: begin
                // reload for the bottom row fill on the final copy step
                o_cmd.sweep_op       = SWEEP_COPY;
                o_cmd.sweep_load     = i_status.copy_last;
                o_cmd.sweep_from_row = 1'b1;
            end
            S_FILL: begin
                o_cmd.sweep_op = SWEEP_FILL;
            end
            S_WRITE: begin
                o_cmd.do_write = 1'b1;
            end
            S_READ: begin
                o_cmd.do_read = 1'b1;
            end
            S_RESP: begin
                o_cmd.load_result = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted transfer not followed by decode");

    a_init_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |=> (r_state != S_INIT))
        else $error("clearing pass re-entered outside reset");

    a_copy_then_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && i_status.copy_last) |=> (r_state == S_FILL))
        else $error("row copy not followed by bottom row blanking");

endmodule

// File: hw/rtl/tccw_datapath.sv
// ============================================================================
// Text console character writer: datapath
// Cursor registers, command decode, cell store with sweep counter, result.
// ============================================================================
module tccw_datapath
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  t_in               i_in_data,
    input  logic [ATTR_W-1:0] i_color_attr,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out              o_out_data
);

    // Item and cursor state
    t_in               r_item;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CUR_W-1:0]  r_cursor;

    // Pending work from decode
    logic              r_pend_scroll;
    logic              r_pend_clear;
    logic              r_pend_wr;
    logic              r_pend_rd;
    logic [CELL_W-1:0] r_wr_addr;
    logic [CHAR_W-1:0] r_wr_char;

    // Sweep and store
    logic [SW_W-1:0]   r_sw;
    logic [WORD_W-1:0] r_mem [CELLS];
    logic [WORD_W-1:0] r_rdata;

    // Result register
    logic              r_out_valid;
    t_out              r_out_data;

    // Decode results
    logic [ROW_W-1:0]  d_row;
    logic [COL_W-1:0]  d_col;
    logic              d_scroll;
    logic              d_clear;
    logic              d_rd;
    logic              d_plus;
    logic              d_keep;
    logic              d_del_shift;
    logic [CHAR_W-1:0] d_char;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_tab;
    logic              wrap;
    logic [CALC_W-1:0] pos;
    logic [CALC_W-1:0] wr_full;
    logic [CALC_W-1:0] cur_full;
    logic              d_wr;

    // Store ports
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CELL_W-1:0] mem_raddr;
    logic [SW_W-1:0]   sw_prev;
    logic [SW_W-1:0]   sw_src;
    logic [ATTR_W-1:0] fill_attr;
    logic              out_free;

    assign row_inc = {1'b0, r_row} + (ROW_W+1)'(1);
    assign col_tab = {1'b0, r_col} + (COL_W+1)'(TAB_STEP);
    assign wrap    = r_col >= COL_W'(COLUMNS - RIGHT_PAD);

    always_comb begin
        d_row       = r_row;
        d_col       = r_col;
        d_scroll    = 1'b0;
        d_clear     = 1'b0;
        d_rd        = 1'b0;
        d_plus      = 1'b0;
        d_keep      = 1'b1;
        d_del_shift = 1'b0;
        d_char      = CHAR_BLANK;
        d_wr        = 1'b0;
        unique case (r_item.cmd)
            CMD_PUT: begin
                d_keep = 1'b0;
                if (r_item.char_code == CHAR_NEWLINE) begin
                    d_col = '0;
                    if (row_inc >= (ROW_W+1)'(ROWS)) begin
                        d_scroll = 1'b1;
                        d_row    = ROW_W'(ROWS - 1);
                    end else begin
                        d_row = row_inc[ROW_W-1:0];
                    end
                end else if (r_item.char_code == CHAR_TAB) begin
                    if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                        d_scroll = 1'b1;
                        d_row    = ROW_W'(ROWS - 1);
                        d_col    = '0;
                    end else begin
                        d_col = col_tab[COL_W-1:0];
                    end
                end else begin
                    // advance the column before the write, wrapping at the pad
                    d_plus = 1'b1;
                    d_wr   = 1'b1;
                    d_char = r_item.char_code;
                    if (wrap) begin
                        d_col = COL_W'(1);
                        if (row_inc >= (ROW_W+1)'(ROWS)) begin
                            d_scroll = 1'b1;
                            d_row    = ROW_W'(ROWS - 1);
                        end else begin
                            d_row = row_inc[ROW_W-1:0];
                        end
                    end else begin
                        d_col = r_col + COL_W'(1);
                    end
                end
            end
            CMD_CLEAR: begin
                d_clear = 1'b1;
                d_row   = '0;
                d_col   = '0;
            end
            CMD_DELETE: begin
                d_keep = 1'b0;
                d_plus = 1'b1;
                d_wr   = 1'b1;
                if (r_col != '0) begin
                    d_col       = r_col - COL_W'(1);
                    d_del_shift = 1'b1;
                end
            end
            CMD_READ: begin
                d_rd = 32'(r_item.cell_addr) < 32'(CELLS);
            end
            default: begin
                d_keep = 1'b1;
            end
        endcase
    end

    assign pos      = CALC_W'(d_row) * CALC_W'(COLUMNS) + CALC_W'(d_col);
    assign wr_full  = d_del_shift ? pos + CALC_W'(1) : pos;
    assign cur_full = d_plus ? pos + CALC_W'(1) : pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_col         <= '0;
            r_cursor      <= '0;
            r_pend_scroll <= 1'b0;
            r_pend_clear  <= 1'b0;
            r_pend_wr     <= 1'b0;
            r_pend_rd     <= 1'b0;
        end else if (i_cmd.decode) begin
            r_row         <= d_row;
            r_col         <= d_col;
            if (!d_keep) r_cursor <= CUR_W'(cur_full);
            r_pend_scroll <= d_scroll;
            r_pend_clear  <= d_clear;
            // drop a write that lands beyond the store
            r_pend_wr     <= d_wr && (wr_full < CALC_W'(CELLS));
            r_pend_rd     <= d_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in_data;
        if (i_cmd.decode) begin
            r_wr_addr <= CELL_W'(wr_full);
            r_wr_char <= d_char;
        end
    end

    // Sweep counter: copy runs one step past the last read to drain the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0;
        end else if (i_cmd.sweep_load) begin
            r_sw <= i_cmd.sweep_from_row ? SW_W'(CELLS - COLUMNS) : '0;
        end else if (i_cmd.sweep_op != SWEEP_NONE) begin
            r_sw <= r_sw + SW_W'(1);
        end
    end

    assign sw_prev   = r_sw - SW_W'(1);
    assign sw_src    = r_sw + SW_W'(COLUMNS);
    assign fill_attr = i_cmd.reset_attr ? ATTR_RESET : i_color_attr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (i_cmd.sweep_op)
            SWEEP_COPY: begin
                if (r_sw != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = sw_prev[CELL_W-1:0];
                    mem_wdata = r_rdata;
                end
                if (r_sw < SW_W'(CELLS - COLUMNS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = sw_src[CELL_W-1:0];
                end
            end
            SWEEP_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_sw[CELL_W-1:0];
                mem_wdata = {fill_attr, CHAR_BLANK};
            end
            default: begin
                if (i_cmd.do_write) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_addr;
                    mem_wdata = {i_color_attr, r_wr_char};
                end
                if (i_cmd.do_read) begin
                    mem_re    = 1'b1;
                    mem_raddr = CELL_W'(r_item.cell_addr);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    // Result register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_data.cursor_pos <= r_cursor;
            r_out_data.cur_row    <= 5'(r_row);
            r_out_data.cur_column <= 7'(r_col);
            r_out_data.cell_data  <= r_pend_rd ? r_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.pend_scroll = r_pend_scroll;
    assign o_status.pend_clear  = r_pend_clear;
    assign o_status.pend_wr     = r_pend_wr;
    assign o_status.pend_rd     = r_pend_rd;
    assign o_status.copy_last   = r_sw == SW_W'(CELLS - COLUMNS);
    assign o_status.fill_last   = r_sw == SW_W'(CELLS - 1);
    assign o_status.out_free    = out_free;

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(CELLS)))
        else $error("cell write beyond the store");

    a_copy_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_op == SWEEP_COPY && r_sw != '0) |-> $past(mem_re))
        else $error("row copy write without a preceding read");

    a_scroll_or_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_scroll && r_pend_clear))
        else $error("scroll and clear pending together");

endmodule
